>>> design/gppm_pkg.sv
// shared constants and types for the greedy point pair matcher
package gppm_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int COORD_W     = 16;
    localparam int PT_W        = 3 * COORD_W;
    localparam int DIST_W      = 35;
    localparam int OUT_IDX_W   = 6;
    localparam int SQ_W        = 2 * COORD_W;

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_CMP,
        ST_SEND,
        ST_FLUSH
    } t_state;

endpackage

>>> design/gppm_ram.sv
// point memory: one write port, one registered read port
module gppm_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [gppm_pkg::IDX_W-1:0]    i_waddr,
    input  logic [gppm_pkg::PT_W-1:0]     i_wdata,
    input  logic [gppm_pkg::IDX_W-1:0]    i_raddr,
    output logic [gppm_pkg::PT_W-1:0]     o_rdata
);

    logic [gppm_pkg::PT_W-1:0] r_mem [gppm_pkg::MAX_POINTS];
    logic [gppm_pkg::PT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/greedy_point_pair_matcher_top.sv
// top level of the greedy point pair matcher: sequencer, shared squarer, point memories
// loads and clears never raise busy; a run scans all count_a * count_b pairs once per found
// match and once more to end, each pair stepping through one shared 17x17 squarer (read,
// three square-accumulate steps, compare), plus a send step after each scan; a flush step
// replaces the last scan at 64 results; the last result shows as busy falls and a new start
// is taken that cycle
// one-cycle result strobes, no stall; sync reset clears counts, marks, threshold, control
module greedy_point_pair_matcher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_mode,
    input  logic signed [gppm_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [gppm_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [gppm_pkg::COORD_W-1:0] i_coord_z,
    input  logic                                i_cfg_we,
    input  logic [gppm_pkg::DIST_W-1:0]         i_cfg_wdata,
    output logic                                o_result_valid,
    output logic                                o_pair_found,
    output logic [gppm_pkg::OUT_IDX_W-1:0]      o_index_a,
    output logic [gppm_pkg::OUT_IDX_W-1:0]      o_index_b,
    output logic [gppm_pkg::DIST_W-1:0]         o_dist_sq,
    output logic                                o_last
);

    gppm_pkg::t_state r_state, n_state;

    logic [gppm_pkg::DIST_W-1:0]      r_max_dist;
    logic [gppm_pkg::CNT_W-1:0]       r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [gppm_pkg::MAX_POINTS-1:0]  r_match_a, n_match_a, r_match_b, n_match_b;
    logic [gppm_pkg::IDX_W-1:0]       r_ia, n_ia, r_ib, n_ib;
    logic [gppm_pkg::DIST_W-1:0]      r_acc, n_acc;
    logic                             r_have, n_have;
    logic [gppm_pkg::IDX_W-1:0]       r_best_a, n_best_a, r_best_b, n_best_b;
    logic [gppm_pkg::DIST_W-1:0]      r_best_d, n_best_d;
    logic                             r_pend_v, n_pend_v;
    logic [gppm_pkg::IDX_W-1:0]       r_pend_a, n_pend_a, r_pend_b, n_pend_b;
    logic [gppm_pkg::DIST_W-1:0]      r_pend_d, n_pend_d;
    logic [gppm_pkg::RES_CNT_W-1:0]   r_nfound, n_nfound;
    logic                             r_out_v, n_out_v;
    logic                             r_out_found, n_out_found;
    logic [gppm_pkg::OUT_IDX_W-1:0]   r_out_a, n_out_a, r_out_b, n_out_b;
    logic [gppm_pkg::DIST_W-1:0]      r_out_d, n_out_d;
    logic                             r_out_last, n_out_last;

    logic                             accept;
    gppm_pkg::t_mode                  mode;
    logic                             we_a, we_b;
    logic [gppm_pkg::PT_W-1:0]        wdata;
    logic [gppm_pkg::PT_W-1:0]        pt_a, pt_b;
    logic signed [gppm_pkg::COORD_W-1:0] op_a, op_b;
    logic signed [gppm_pkg::COORD_W:0]   diff;
    logic signed [2*gppm_pkg::COORD_W+1:0] prod;
    logic [gppm_pkg::DIST_W-1:0]      sq_ext;
    logic                             empty_set;
    logic                             last_b, last_a;
    logic                             eligible;
    logic                             limit_hit;

    assign accept    = start && !busy;
    assign mode      = gppm_pkg::t_mode'(i_mode);
    assign wdata     = {i_coord_x, i_coord_y, i_coord_z};
    assign we_a      = accept && (mode == gppm_pkg::MODE_LOAD_A) &&
                       (r_cnt_a != gppm_pkg::CNT_W'(gppm_pkg::MAX_POINTS));
    assign we_b      = accept && (mode == gppm_pkg::MODE_LOAD_B) &&
                       (r_cnt_b != gppm_pkg::CNT_W'(gppm_pkg::MAX_POINTS));
    assign empty_set = (r_cnt_a == '0) || (r_cnt_b == '0);

    gppm_ram u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[gppm_pkg::IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ia),
        .o_rdata (pt_a)
    );

    gppm_ram u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[gppm_pkg::IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ib),
        .o_rdata (pt_b)
    );

    // shared squarer: one coordinate difference per cycle
    always_comb begin
        unique case (r_state)
            gppm_pkg::ST_SQ_Y: begin
                op_a = pt_a[2*gppm_pkg::COORD_W-1:gppm_pkg::COORD_W];
                op_b = pt_b[2*gppm_pkg::COORD_W-1:gppm_pkg::COORD_W];
            end
            gppm_pkg::ST_SQ_Z: begin
                op_a = pt_a[gppm_pkg::COORD_W-1:0];
                op_b = pt_b[gppm_pkg::COORD_W-1:0];
            end
            default: begin
                op_a = pt_a[gppm_pkg::PT_W-1:2*gppm_pkg::COORD_W];
                op_b = pt_b[gppm_pkg::PT_W-1:2*gppm_pkg::COORD_W];
            end
        endcase
    end

    assign diff   = $signed({op_a[gppm_pkg::COORD_W-1], op_a}) -
                    $signed({op_b[gppm_pkg::COORD_W-1], op_b});
    assign prod   = diff * diff;
    // square of a 17-bit difference stays below 2^32
    assign sq_ext = gppm_pkg::DIST_W'(prod[gppm_pkg::SQ_W-1:0]);

    assign last_b    = ({1'b0, r_ib} + 1'b1) == r_cnt_b;
    assign last_a    = ({1'b0, r_ia} + 1'b1) == r_cnt_a;
    assign eligible  = !r_match_a[r_ia] && !r_match_b[r_ib] && (r_acc < r_max_dist) &&
                       (!r_have || (r_acc < r_best_d));
    assign limit_hit = (r_nfound + 1'b1) == gppm_pkg::RES_CNT_W'(gppm_pkg::MAX_RESULTS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gppm_pkg::ST_IDLE: begin
                if (accept && (mode == gppm_pkg::MODE_RUN)) begin
                    n_state = empty_set ? gppm_pkg::ST_SEND : gppm_pkg::ST_READ;
                end
            end
            gppm_pkg::ST_READ:  n_state = gppm_pkg::ST_SQ_X;
            gppm_pkg::ST_SQ_X:  n_state = gppm_pkg::ST_SQ_Y;
            gppm_pkg::ST_SQ_Y:  n_state = gppm_pkg::ST_SQ_Z;
            gppm_pkg::ST_SQ_Z:  n_state = gppm_pkg::ST_CMP;
            gppm_pkg::ST_CMP: begin
                n_state = (last_a && last_b) ? gppm_pkg::ST_SEND : gppm_pkg::ST_READ;
            end
            gppm_pkg::ST_SEND: begin
                if (!r_have) begin
                    n_state = gppm_pkg::ST_IDLE;
                end else if (limit_hit) begin
                    n_state = gppm_pkg::ST_FLUSH;
                end else begin
                    n_state = gppm_pkg::ST_READ;
                end
            end
            gppm_pkg::ST_FLUSH: n_state = gppm_pkg::ST_IDLE;
            default:            n_state = gppm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_match_a   = r_match_a;
        n_match_b   = r_match_b;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_acc       = r_acc;
        n_have      = r_have;
        n_best_a    = r_best_a;
        n_best_b    = r_best_b;
        n_best_d    = r_best_d;
        n_pend_v    = r_pend_v;
        n_pend_a    = r_pend_a;
        n_pend_b    = r_pend_b;
        n_pend_d    = r_pend_d;
        n_nfound    = r_nfound;
        n_out_v     = 1'b0;
        n_out_found = r_out_found;
        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        n_out_d     = r_out_d;
        n_out_last  = r_out_last;
        unique case (r_state)
            gppm_pkg::ST_IDLE: begin
                if (we_a) begin
                    n_cnt_a = r_cnt_a + 1'b1;
                end
                if (we_b) begin
                    n_cnt_b = r_cnt_b + 1'b1;
                end
                if (accept && (mode == gppm_pkg::MODE_CLEAR)) begin
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_match_a = '0;
                    n_match_b = '0;
                end
                if (accept && (mode == gppm_pkg::MODE_RUN)) begin
                    n_match_a = '0;
                    n_match_b = '0;
                    n_ia      = '0;
                    n_ib      = '0;
                    n_have    = 1'b0;
                    n_pend_v  = 1'b0;
                    n_nfound  = '0;
                end
            end
            gppm_pkg::ST_SQ_X: n_acc = sq_ext;
            gppm_pkg::ST_SQ_Y: n_acc = r_acc + sq_ext;
            gppm_pkg::ST_SQ_Z: n_acc = r_acc + sq_ext;
            gppm_pkg::ST_CMP: begin
                if (eligible) begin
                    n_have   = 1'b1;
                    n_best_a = r_ia;
                    n_best_b = r_ib;
                    n_best_d = r_acc;
                end
                if (last_b) begin
                    n_ib = '0;
                    if (!last_a) begin
                        n_ia = r_ia + 1'b1;
                    end
                end else begin
                    n_ib = r_ib + 1'b1;
                end
            end
            gppm_pkg::ST_SEND: begin
                if (r_have) begin
                    // the previous pair goes out now that another one follows it
                    n_match_a[r_best_a] = 1'b1;
                    n_match_b[r_best_b] = 1'b1;
                    if (r_pend_v) begin
                        n_out_v     = 1'b1;
                        n_out_found = 1'b1;
                        n_out_a     = gppm_pkg::OUT_IDX_W'(r_pend_a);
                        n_out_b     = gppm_pkg::OUT_IDX_W'(r_pend_b);
                        n_out_d     = r_pend_d;
                        n_out_last  = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_a = r_best_a;
                    n_pend_b = r_best_b;
                    n_pend_d = r_best_d;
                    n_nfound = r_nfound + 1'b1;
                    n_ia     = '0;
                    n_ib     = '0;
                    n_have   = 1'b0;
                end else begin
                    n_out_v     = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_found = r_pend_v;
                    n_out_a     = r_pend_v ? gppm_pkg::OUT_IDX_W'(r_pend_a) : '0;
                    n_out_b     = r_pend_v ? gppm_pkg::OUT_IDX_W'(r_pend_b) : '0;
                    n_out_d     = r_pend_v ? r_pend_d : '0;
                end
            end
            gppm_pkg::ST_FLUSH: begin
                n_out_v     = 1'b1;
                n_out_found = 1'b1;
                n_out_a     = gppm_pkg::OUT_IDX_W'(r_pend_a);
                n_out_b     = gppm_pkg::OUT_IDX_W'(r_pend_b);
                n_out_d     = r_pend_d;
                n_out_last  = 1'b1;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gppm_pkg::ST_IDLE;
            r_max_dist <= '0;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_match_a  <= '0;
            r_match_b  <= '0;
            r_have     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_nfound   <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_max_dist <= i_cfg_wdata;
            end
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_match_a <= n_match_a;
            r_match_b <= n_match_b;
            r_have    <= n_have;
            r_pend_v  <= n_pend_v;
            r_nfound  <= n_nfound;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia        <= n_ia;
        r_ib        <= n_ib;
        r_acc       <= n_acc;
        r_best_a    <= n_best_a;
        r_best_b    <= n_best_b;
        r_best_d    <= n_best_d;
        r_pend_a    <= n_pend_a;
        r_pend_b    <= n_pend_b;
        r_pend_d    <= n_pend_d;
        r_out_found <= n_out_found;
        r_out_a     <= n_out_a;
        r_out_b     <= n_out_b;
        r_out_d     <= n_out_d;
        r_out_last  <= n_out_last;
    end

    assign busy           = (r_state != gppm_pkg::ST_IDLE);
    assign o_result_valid = r_out_v;
    assign o_pair_found   = r_out_found;
    assign o_index_a      = r_out_a;
    assign o_index_b      = r_out_b;
    assign o_dist_sq      = r_out_d;
    assign o_last         = r_out_last;

endmodule

>>> design/gppm_checker.sv
// port-level checker for the greedy point pair matcher, bound to the top level
module gppm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          i_mode,
    input logic                                o_result_valid,
    input logic                                o_pair_found,
    input logic [gppm_pkg::OUT_IDX_W-1:0]      o_index_a,
    input logic [gppm_pkg::OUT_IDX_W-1:0]      o_index_b,
    input logic [gppm_pkg::DIST_W-1:0]         o_dist_sq,
    input logic                                o_last
);

    // a not-found transfer is the only one of its run and carries zeros
    a_not_found_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_pair_found) |->
            (o_last && (o_index_a == '0) && (o_index_b == '0) && (o_dist_sq == '0)))
        else $error("not-found result malformed");

    // the final transfer of a run coincides with the block going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |-> !busy)
        else $error("busy after last result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> busy)
        else $error("run ended without last flag");

    // loads and clears finish at once and emit nothing
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_mode == gppm_pkg::MODE_LOAD_A) ||
                            (i_mode == gppm_pkg::MODE_LOAD_B) ||
                            (i_mode == gppm_pkg::MODE_CLEAR)))
            |=> (!busy && !o_result_valid))
        else $error("load or clear produced activity");

endmodule

bind greedy_point_pair_matcher_top gppm_checker u_gppm_checker (.*);
